// ===== design/rxl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxl_pkg
// Shared types, constants and helper functions for the enciphered LZSS
// byte decoder: header layout, window geometry and the front-to-back command.
// ----------------------------------------------------------------------------
package rxl_pkg;

  // Header layout
  localparam int HDR_BYTES  = 48;
  localparam int HDR_IDX_W  = 6;
  localparam int KEY_FIRST  = 12;
  localparam int KEY_LAST   = 15;
  localparam int SIZE_FIRST = 'h28;
  localparam int SIZE_LAST  = 'h2B;

  // History window
  localparam int WIN_BYTES  = 2048;
  localparam int WIN_AW     = $clog2(WIN_BYTES);
  localparam logic [WIN_AW-1:0] WP_START = WIN_AW'('h7DF);

  // Match fields
  localparam int LEN_W      = 6;
  localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(2);

  // Decipher constants
  localparam logic [7:0] SUB_BIAS = 8'h7C;

  // Command queue between front and back
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);

  // Kind of work the back end carries out
  typedef enum logic [1:0] {
    CMD_HDR   = 2'd0,  // header byte: emit only
    CMD_LIT   = 2'd1,  // literal: emit and store in window
    CMD_MATCH = 2'd2,  // copy from window
    CMD_CLEAR = 2'd3   // end of file with no output
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;     // byte for header or literal words
    logic [WIN_AW-1:0] offset;   // match source
    logic [LEN_W-1:0]  len;      // match length, 2..33
    logic              file_end; // return window to reset after this command
  } cmd_t;

  // Queue write side and read side
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  // Rotate amount (k >> 20) % 5 + 1. 16 = 1 mod 5, so the three nibbles are
  // summed first, then the small sum is reduced with a reciprocal multiply.
  function automatic logic [2:0] rot_amount(input logic [31:0] key);
    logic [11:0] t;
    logic [5:0]  s;
    logic [9:0]  p;
    logic [3:0]  q;
    logic [5:0]  r;
    t = key[31:20];
    s = {2'b00, t[3:0]} + {2'b00, t[7:4]} + {2'b00, t[11:8]};
    p = {4'b0000, s} * 10'd13;
    q = p[9:6];
    r = s - ({2'b00, q} * 6'd5);
    return r[2:0] + 3'd1;
  endfunction

  // Subtract bias, mix with key, rotate right
  function automatic logic [7:0] decipher(input logic [7:0] b, input logic [31:0] key);
    logic [7:0]  mix;
    logic [7:0]  v;
    logic [2:0]  sh;
    logic [15:0] dbl;
    mix = key[31:24] + key[10:3];
    v   = (b - SUB_BIAS) ^ mix;
    sh  = rot_amount(key);
    dbl = {v, v} >> sh;
    return dbl[7:0];
  endfunction

endpackage

// ===== design/rxl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxl_if
// Valid/ready channels for raw file bytes in and decoded bytes out.
// ----------------------------------------------------------------------------
interface rxl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_end;

  modport source (output valid, output in_byte, output file_end, input ready);
  modport sink   (input valid, input in_byte, input file_end, output ready);
endinterface

interface rxl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== design/rxl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxl_front
// Accepts raw bytes, tracks the header, deciphers payload bytes and turns
// them into commands for the back end. Keeps flags, pending match byte and
// the payload count, so it waits on the back end only when the queue is full.
// ----------------------------------------------------------------------------
module rxl_front (
  input  logic          clk,
  input  logic          rst,
  rxl_in_if.sink        in_ch,
  input  logic          q_full,
  output rxl_pkg::q_wr_t q_wr
);
  import rxl_pkg::*;

  logic [HDR_IDX_W-1:0] header_index;
  logic [31:0]          header_key;
  logic [31:0]          target_size;
  logic [8:0]           flag_bits;
  logic [7:0]           pending_low;
  logic                 have_low;
  logic [31:0]          produced_count;

  logic [HDR_IDX_W-1:0] header_index_next;
  logic [31:0]          header_key_next;
  logic [31:0]          target_size_next;
  logic [8:0]           flag_bits_next;
  logic [7:0]           pending_low_next;
  logic                 have_low_next;
  logic [31:0]          produced_count_next;

  logic                 accept;
  logic [7:0]           plain;
  logic                 size_reached;
  logic [LEN_W-1:0]     match_len;
  logic [32:0]          cnt_sum;
  logic                 gen;
  cmd_t                 cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign plain        = decipher(in_ch.in_byte, header_key);
  assign size_reached = target_size[31] || (produced_count >= target_size);
  assign match_len    = {1'b0, plain[4:0]} + LEN_BIAS;

  // Classify the word and work out the next state
  always_comb begin
    header_index_next   = header_index;
    header_key_next     = header_key;
    target_size_next    = target_size;
    flag_bits_next      = flag_bits;
    pending_low_next    = pending_low;
    have_low_next       = have_low;
    produced_count_next = produced_count;
    cnt_sum             = 33'd0;
    gen                 = 1'b0;
    cmd.kind            = CMD_CLEAR;
    cmd.data            = in_ch.in_byte;
    cmd.offset          = {plain[7:5], pending_low};
    cmd.len             = match_len;
    cmd.file_end        = in_ch.file_end;

    if (header_index < HDR_IDX_W'(HDR_BYTES)) begin
      if (header_index >= HDR_IDX_W'(KEY_FIRST) && header_index <= HDR_IDX_W'(KEY_LAST)) begin
        header_key_next[{header_index[1:0], 3'b000} +: 8] = in_ch.in_byte;
      end
      if (header_index >= HDR_IDX_W'(SIZE_FIRST) && header_index <= HDR_IDX_W'(SIZE_LAST)) begin
        target_size_next[{header_index[1:0], 3'b000} +: 8] = in_ch.in_byte;
      end
      header_index_next = header_index + HDR_IDX_W'(1);
      gen      = 1'b1;
      cmd.kind = CMD_HDR;
    end else if (have_low) begin
      // second byte of a match: always runs to full length
      cnt_sum             = {1'b0, produced_count} + {{(33-LEN_W){1'b0}}, match_len};
      produced_count_next = cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
      have_low_next       = 1'b0;
      pending_low_next    = 8'd0;
      flag_bits_next      = {1'b0, flag_bits[8:1]};
      gen      = 1'b1;
      cmd.kind = CMD_MATCH;
    end else if (!size_reached) begin
      if (flag_bits == 9'd1) begin
        flag_bits_next = {1'b1, plain};
      end else if (flag_bits[0]) begin
        cnt_sum             = {1'b0, produced_count} + 33'd1;
        produced_count_next = cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
        flag_bits_next      = {1'b0, flag_bits[8:1]};
        gen      = 1'b1;
        cmd.kind = CMD_LIT;
        cmd.data = plain;
      end else begin
        pending_low_next = plain;
        have_low_next    = 1'b1;
      end
    end

    // a file end with no output still has to reach the window
    if (in_ch.file_end && !gen) begin
      gen      = 1'b1;
      cmd.kind = CMD_CLEAR;
    end
  end

  assign q_wr.push = accept && gen;
  assign q_wr.cmd  = cmd;

  // State registers, returned to reset after the last word of a file
  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.file_end)) begin
      header_index   <= '0;
      header_key     <= '0;
      target_size    <= '0;
      flag_bits      <= 9'd1;
      pending_low    <= '0;
      have_low       <= 1'b0;
      produced_count <= '0;
    end else if (accept) begin
      header_index   <= header_index_next;
      header_key     <= header_key_next;
      target_size    <= target_size_next;
      flag_bits      <= flag_bits_next;
      pending_low    <= pending_low_next;
      have_low       <= have_low_next;
      produced_count <= produced_count_next;
    end
  end

endmodule

// ===== design/rxl_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxl_cmd_queue
// Short command queue between front and back end, so each side stalls on
// its own.
// ----------------------------------------------------------------------------
module rxl_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  rxl_pkg::q_wr_t q_wr,
  output logic           q_full,
  output rxl_pkg::q_rd_t q_rd,
  input  logic           q_pop
);
  import rxl_pkg::*;

  cmd_t              slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign q_full    = (count == (QPTR_W+1)'(Q_DEPTH));
  assign q_rd.valid = (count != '0);
  assign q_rd.cmd   = slots[rd_ptr];
  assign do_pop     = q_pop && q_rd.valid;

  // Storage
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slots[wr_ptr] <= q_wr.cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({q_wr.push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/rxl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxl_back
// Carries out commands: emits header and literal words, copies matches out
// of the 2 KiB history window one word per read and data state, and drives the
// output register. Unwritten window slots read as zero through a fill count.
// ----------------------------------------------------------------------------
module rxl_back (
  input  logic           clk,
  input  logic           rst,
  input  rxl_pkg::q_rd_t q_rd,
  output logic           q_pop,
  rxl_out_if.source      out_ch
);
  import rxl_pkg::*;

  typedef enum logic [2:0] {
    S_FETCH = 3'b001,
    S_READ  = 3'b010,
    S_DATA  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;

  logic [7:0]        win_mem [WIN_BYTES];
  logic [7:0]        rd_data;
  logic              rd_ok;

  logic [WIN_AW-1:0] wp;
  logic [WIN_AW:0]   fill;
  logic [WIN_AW-1:0] cur_off;
  logic [LEN_W-1:0]  cur_len;
  logic              cur_end;
  logic [LEN_W-1:0]  cnt;

  logic              slot_free;
  logic [WIN_AW-1:0] raddr;
  logic [WIN_AW-1:0] win_dist;
  logic              mem_re;
  logic              mem_we;
  logic [7:0]        wdata;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_last;
  logic              win_reset;
  logic              match_last;

  assign slot_free  = !out_ch.valid || out_ch.ready;
  assign raddr      = cur_off + {{(WIN_AW-LEN_W){1'b0}}, cnt};
  assign win_dist   = raddr - WP_START;
  assign match_last = (cnt == cur_len - LEN_W'(1));

  // Command sequencing
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    wdata      = q_rd.cmd.data;
    emit       = 1'b0;
    emit_byte  = q_rd.cmd.data;
    emit_last  = 1'b1;
    win_reset  = 1'b0;
    unique case (state)
      S_FETCH: begin
        if (q_rd.valid) begin
          unique case (q_rd.cmd.kind)
            CMD_HDR: begin
              if (slot_free) begin
                q_pop     = 1'b1;
                emit      = 1'b1;
                win_reset = q_rd.cmd.file_end;
              end
            end
            CMD_LIT: begin
              if (slot_free) begin
                q_pop     = 1'b1;
                emit      = 1'b1;
                mem_we    = 1'b1;
                win_reset = q_rd.cmd.file_end;
              end
            end
            CMD_MATCH: begin
              q_pop      = 1'b1;
              state_next = S_READ;
            end
            CMD_CLEAR: begin
              q_pop     = 1'b1;
              win_reset = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        mem_re     = 1'b1;
        state_next = S_DATA;
      end
      S_DATA: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = rd_ok ? rd_data : 8'd0;
          emit_last = match_last;
          mem_we    = 1'b1;
          wdata     = emit_byte;
          if (match_last) begin
            win_reset  = cur_end;
            state_next = S_FETCH;
          end else begin
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_FETCH;
    endcase
  end

  // Window storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wp] <= wdata;
    end
    if (mem_re) begin
      rd_data <= win_mem[raddr];
      rd_ok   <= fill[WIN_AW] || ({1'b0, win_dist} < fill);
    end
  end

  // Match registers
  always_ff @(posedge clk) begin
    if (state == S_FETCH && q_pop && q_rd.cmd.kind == CMD_MATCH) begin
      cur_off <= q_rd.cmd.offset;
      cur_len <= q_rd.cmd.len;
      cur_end <= q_rd.cmd.file_end;
      cnt     <= '0;
    end else if (state == S_DATA && slot_free) begin
      cnt <= cnt + LEN_W'(1);
    end
  end

  // Control: state, write pointer, fill count, output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FETCH;
      wp           <= WP_START;
      fill         <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (win_reset) begin
        wp   <= WP_START;
        fill <= '0;
      end else if (mem_we) begin
        wp <= wp + WIN_AW'(1);
        if (!fill[WIN_AW]) begin
          fill <= fill + (WIN_AW+1)'(1);
        end
      end
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.out_byte <= emit_byte;
      out_ch.run_last <= emit_last;
    end
  end

  // Checks
  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> (cnt < cur_len))
    else $error("match counter past match length");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (WIN_AW+1)'(WIN_BYTES))
    else $error("window fill count above window size");

  a_file_end_restart: assert property (@(posedge clk) disable iff (rst)
    win_reset |=> (wp == WP_START && fill == '0))
    else $error("window not returned to start after end of file");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("output word overwritten before it was taken");

endmodule

// ===== design/rotate_xor_lzss_byte_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_xor_lzss_byte_decoder
// Deciphers and LZSS-expands a packed file fed one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one raw file byte per word, with file_end set on the last
//   byte of the file. out_ch gives header bytes and decoded payload bytes;
//   run_last marks the final output word caused by one input word.
//   The front end classifies each word in the cycle it is accepted and
//   pushes at most one command into a two-entry queue; control bytes and
//   match low bytes produce no command unless they carry file_end.
//   A header or literal word passes through a queue slot and the output
//   register on its way to out_ch. A match occupies the back end for a
//   fetch and then one window read and one write per output word on the
//   single-port window memory, so the back end pops no new command until
//   the match is done; literals and header bytes need only the fetch.
//   in_ch.ready drops only when the queue is full.
//   The 2 KiB window is tracked by a fill count, so no clearing pass is
//   needed: reset and the end of each file return it to empty at once.
//   Reset (rst, synchronous) drops all queued work and any output word.
//   When out_ch stalls the output register holds its word, the back end
//   waits, and the queue fills before in_ch is held off.
// ----------------------------------------------------------------------------
module rotate_xor_lzss_byte_decoder (
  input  logic      clk,
  input  logic      rst,
  rxl_in_if.sink    in_ch,
  rxl_out_if.source out_ch
);
  import rxl_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  rxl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  rxl_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  rxl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== dv/rotate_xor_lzss_byte_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_xor_lzss_byte_decoder_tb
// Self-checking bench for the enciphered LZSS byte decoder. Whole files are
// built from planned literal/match streams, enciphered under fixed or random
// keys and fed in with bursty valid; the output side stalls in changing patterns.
// A behavioural decoder in the bench predicts every output word, which is
// checked in order against what the block returns.
// ----------------------------------------------------------------------------
module rotate_xor_lzss_byte_decoder_tb;
  import rxl_pkg::*;

  typedef struct {
    logic [7:0] raw;
    logic       fe;     // last byte of its file
    bit         drain;  // hold back until all owed output has arrived
  } file_word_t;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
  } out_word_t;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_COMB, SINK_CHOKE} sink_mode_t;

  logic clk = 1'b0;
  logic rst;

  rxl_in_if  in_ch ();
  rxl_out_if out_ch ();

  rotate_xor_lzss_byte_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Pending raw words and the decoded words still owed by the block
  file_word_t file_words [$];
  out_word_t  decoded_q [$];
  int         owed_cnt = 0;

  int err_count = 0;
  int words_in = 0, words_out = 0;
  int n_files = 0, n_literals = 0, n_matches = 0, n_ignored = 0;

  // --------------------------------------------------------------------------
  // Behavioural decoder state
  // --------------------------------------------------------------------------
  logic [5:0]        hdr_idx;
  logic [31:0]       file_key;
  logic [31:0]       size_limit;
  logic [31:0]       produced;
  logic [8:0]        flags;      // guard bit above the flags still to use
  logic [7:0]        low_byte;
  logic              low_held;
  logic [WIN_AW-1:0] wptr;
  logic [7:0]        history [0:WIN_BYTES-1];

  function automatic void clear_decoder();
    hdr_idx    = '0;
    file_key   = '0;
    size_limit = '0;
    produced   = '0;
    flags      = 9'h001;
    low_byte   = '0;
    low_held   = 1'b0;
    wptr       = WP_START;
    foreach (history[i]) history[i] = 8'h00;
  endfunction

  function automatic logic [7:0] plain_of(logic [7:0] raw);
    logic [7:0] mix;
    logic [7:0] v;
    int         sh;
    mix = file_key[31:24] + file_key[10:3];
    sh  = (file_key >> 20) % 5 + 1;
    v   = (raw - SUB_BIAS) ^ mix;
    return (v >> sh) | (v << (8 - sh));
  endfunction

  function automatic void emit_payload(logic [7:0] b);
    decoded_q.push_back('{b, 1'b0});
    history[wptr] = b;
    wptr = wptr + 1'b1;
    if (produced != 32'hFFFF_FFFF) produced++;
  endfunction

  // One accepted raw word: queue the decoded words it gives rise to
  function automatic void decode_raw_byte(logic [7:0] raw, logic fe);
    int                first;
    int                len;
    logic [7:0]        p;
    logic [WIN_AW-1:0] src;
    first = decoded_q.size();
    if (hdr_idx < HDR_BYTES) begin
      if (hdr_idx >= KEY_FIRST && hdr_idx <= KEY_LAST)
        file_key |= 32'(raw) << (8 * (hdr_idx - KEY_FIRST));
      if (hdr_idx >= SIZE_FIRST && hdr_idx <= SIZE_LAST)
        size_limit |= 32'(raw) << (8 * (hdr_idx - SIZE_FIRST));
      hdr_idx++;
      decoded_q.push_back('{raw, 1'b0});
    end else begin
      p = plain_of(raw);
      if (low_held) begin
        // second byte of a match: copy runs to full length regardless of size
        src = {p[7:5], low_byte};
        len = int'(p[4:0]) + 2;
        for (int j = 0; j < len; j++) emit_payload(history[src + WIN_AW'(j)]);
        low_held = 1'b0;
        low_byte = '0;
        flags    = flags >> 1;
        n_matches++;
      end else if (size_limit[31] || produced >= size_limit) begin
        n_ignored++;
      end else if (flags == 9'h001) begin
        flags = {1'b1, p};
      end else if (flags[0]) begin
        emit_payload(p);
        flags = flags >> 1;
        n_literals++;
      end else begin
        low_byte = p;
        low_held = 1'b1;
      end
    end
    if (decoded_q.size() > first) decoded_q[$].run_last = 1'b1;
    if (fe) begin
      clear_decoder();
      n_files++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // File builder: plans plain streams and enciphers them
  // --------------------------------------------------------------------------
  logic [31:0]       gen_key;
  logic [WIN_AW-1:0] gen_wp;

  function automatic logic [7:0] encipher(logic [7:0] p, logic [31:0] k);
    logic [7:0] mix;
    logic [7:0] v;
    int         sh;
    mix = k[31:24] + k[10:3];
    sh  = (k >> 20) % 5 + 1;
    v   = (p << sh) | (p >> (8 - sh));
    return (v ^ mix) + SUB_BIAS;
  endfunction

  function automatic void put_raw(logic [7:0] r);
    file_words.push_back('{r, 1'b0, 1'b0});
  endfunction

  function automatic void put_plain(logic [7:0] p);
    put_raw(encipher(p, gen_key));
  endfunction

  function automatic void put_literal(logic [7:0] p);
    put_plain(p);
    gen_wp = gen_wp + 1'b1;
  endfunction

  function automatic void put_match(logic [WIN_AW-1:0] off, logic [4:0] lf);
    put_plain(off[7:0]);
    put_plain({off[10:8], lf});
    gen_wp = gen_wp + WIN_AW'(lf) + WIN_AW'(2);
  endfunction

  // count below the header length gives a file cut short inside the header
  function automatic void put_header(logic [31:0] k, logic [31:0] sz, int count, bit drain);
    int         first;
    logic [7:0] b;
    first = file_words.size();
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if (i >= KEY_FIRST && i <= KEY_LAST) b = k[8*(i-KEY_FIRST) +: 8];
      if (i >= SIZE_FIRST && i <= SIZE_LAST) b = sz[8*(i-SIZE_FIRST) +: 8];
      put_raw(b);
    end
    file_words[first].drain = drain;
    if (count < HDR_BYTES) file_words[$].fe = 1'b1;
    gen_key = k;
    gen_wp  = WP_START;
  endfunction

  // Random groups of literals and matches; a cut-off file ends on a match low byte
  function automatic void put_payload(int budget, bit cut_off);
    int                start;
    int                pick;
    logic [7:0]        ctl;
    logic [WIN_AW-1:0] off;
    logic [4:0]        lf;
    start = file_words.size();
    while (file_words.size() - start < budget) begin
      pick = $urandom_range(0, 5);
      ctl  = (pick == 0) ? 8'hFF : (pick == 1) ? 8'h00 : 8'($urandom);
      put_plain(ctl);
      for (int f = 0; f < 8; f++) begin
        if (!cut_off && file_words.size() - start >= budget) break;
        if (ctl[f]) begin
          put_literal(8'($urandom));
        end else begin
          off = ($urandom_range(0, 4) == 0) ? WIN_AW'($urandom)
                                            : gen_wp - WIN_AW'($urandom_range(1, 48));
          pick = $urandom_range(0, 7);
          lf = (pick == 0) ? 5'h1F : (pick == 1) ? 5'h00 : 5'($urandom_range(0, 12));
          put_match(off, lf);
        end
      end
    end
    if (cut_off) begin
      put_plain(8'h00);
      put_plain(8'($urandom));
    end
    file_words[$].fe = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: bursts and gaps, word held until taken
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    bit go;
    go = 1'b0;
    if (rst) begin
      in_ch.valid    <= 1'b0;
      in_ch.in_byte  <= 8'h00;
      in_ch.file_end <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(file_words.pop_front());
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left != 0)
          gap_left--;
        else if (file_words.size() != 0 &&
                 !(file_words[0].drain && (owed_cnt != 0 || (in_ch.valid && in_ch.ready))))
          go = 1'b1;
        if (go) begin
          in_ch.valid    <= 1'b1;
          in_ch.in_byte  <= file_words[0].raw;
          in_ch.file_end <= file_words[0].fe;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output ready: open, random, comb or choke pattern, each kept for a random run of cycles
  // --------------------------------------------------------------------------
  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_left = 0;
  int         cyc = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      cyc++;
      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_left = $urandom_range(30, 150);
      end else begin
        sink_left--;
      end
      case (sink_mode)
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
        SINK_COMB:   out_ch.ready <= (cyc % 4) != 0;
        default:     out_ch.ready <= (cyc % 12) < 3;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input words, check output words in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      clear_decoder();
      owed_cnt <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_raw_byte(in_ch.in_byte, in_ch.file_end);
        words_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (decoded_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word out_byte %02h run_last %0b",
                   $time, out_ch.out_byte, out_ch.run_last);
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            err_count++;
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.data, out_ch.out_byte);
          end
          if (out_ch.run_last !== want.run_last) begin
            err_count++;
            $display("%0t: run_last expected %0b actual %0b",
                     $time, want.run_last, out_ch.run_last);
          end
        end
      end
      owed_cnt <= decoded_q.size();
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int start;
    int kind;
    logic [31:0] sz;
    rst = 1'b1;

    // file cut short inside the header, byte extremes
    put_raw(8'h00);
    put_raw(8'hFF);
    put_raw(8'h55);
    put_raw(8'hAA);
    put_raw(8'h80);
    file_words[$].fe = 1'b1;

    // zero key: literal extremes, longest match from the top of the window,
    // shortest match from slot zero, overlapping copy, match cut off by the end
    put_header(32'h0000_0000, 32'h7FFF_FFFF, HDR_BYTES, 1'b0);
    put_plain(8'b0001_0101);
    put_literal(8'h00);
    put_match(11'h7FF, 5'h1F);
    put_literal(8'hFF);
    put_match(11'h000, 5'h00);
    put_literal(8'h80);
    put_match(gen_wp - 11'd1, 5'd9);
    put_plain(8'hA5);
    file_words[$].fe = 1'b1;

    // all-ones key, size reached inside a match; the rest is ignored
    put_header(32'hFFFF_FFFF, 32'd3, HDR_BYTES, 1'b1);
    put_plain(8'h01);
    put_literal(8'h5A);
    put_match(gen_wp - 11'd1, 5'd4);
    put_plain(8'hFF);
    put_literal(8'h11);
    file_words[$].fe = 1'b1;

    // random files, one of each kind of ending
    start = file_words.size();
    kind  = 0;
    while (kind < 5) begin
      case (kind % 5)
        0: begin
          sz = {1'b0, 31'($urandom)} | 32'h0001_0000;
          put_header($urandom, sz, HDR_BYTES, kind % 3 == 0);
          put_payload($urandom_range(15, 25), 1'b0);
        end
        1: begin
          put_header($urandom, $urandom_range(0, 20), HDR_BYTES, kind % 3 == 0);
          put_payload($urandom_range(10, 20), 1'b0);
        end
        2: begin
          put_header($urandom, 32'h7FFF_FFFF, HDR_BYTES, kind % 3 == 0);
          put_payload($urandom_range(8, 16), 1'b1);
        end
        3: begin
          sz = {1'b1, 31'($urandom)};
          put_header($urandom, sz, HDR_BYTES, kind % 3 == 0);
          put_payload($urandom_range(4, 8), 1'b0);
        end
        default: put_header($urandom, $urandom, $urandom_range(1, HDR_BYTES - 1), 1'b0);
      endcase
      kind++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (file_words.size() != 0) @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (150) @(posedge clk);

    $display("Run covered %0d files: %0d words in, %0d words out", n_files, words_in,
             words_out);
    $display("Payload: %0d literals, %0d matches, %0d bytes skipped past size", n_literals,
             n_matches, n_ignored);
    if (err_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("Timed out with %0d words owed", decoded_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rxl_pkg.sv
design/rxl_if.sv
design/rxl_front.sv
design/rxl_cmd_queue.sv
design/rxl_back.sv
design/rotate_xor_lzss_byte_decoder.sv
dv/rotate_xor_lzss_byte_decoder_tb.sv
